### hdl/rlebsd_pkg.sv
// Package for the RLE8 bitmap span decoder: decoder phases, status and
// register codes, widths, reset values and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps

package rlebsd_pkg;

  localparam int RowW    = 15;  // row_bytes register
  localparam int ImgW    = 24;  // image_bytes register, span length
  localparam int ColW    = 16;  // column may run a run past a shrunken row
  localparam int DestW   = 25;  // position may run a run past a shrunken image
  localparam int CfgIdxW = 2;

  localparam int DefMaxRowBytes   = 16384;
  localparam int DefMaxImageBytes = 16777215;

  localparam logic [RowW-1:0] RowBytesReset   = 15'd640;
  localparam logic [ImgW-1:0] ImageBytesReset = 24'd307200;
  localparam logic [7:0]      TranspReset     = 8'd0;

  localparam logic [CfgIdxW-1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TRANSPARENT = 2'd2;

  localparam logic [1:0] ST_SPAN  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [3:0] {
    PH_COUNT     = 4'd0,
    PH_ESCAPE    = 4'd1,
    PH_RUN_VALUE = 4'd2,
    PH_DELTA_X   = 4'd3,
    PH_DELTA_Y   = 4'd4,
    PH_LITERAL   = 4'd5,
    PH_PAD       = 4'd6,
    PH_DONE      = 4'd7,
    PH_ERROR     = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       held_count;
    logic [ColW-1:0]  column;
    logic [DestW-1:0] dest_position;
    logic [7:0]       delta_columns;
    logic [7:0]       literal_left;
    logic             pad_pending;
  } dec_state_t;

  typedef struct packed {
    logic            valid;
    logic [7:0]      pixel_value;
    logic [ImgW-1:0] span_length;
    logic [1:0]      status;
  } span_res_t;

  localparam dec_state_t StateStart = '{
    phase:         PH_COUNT,
    held_count:    8'd0,
    column:        '0,
    dest_position: '0,
    delta_columns: 8'd0,
    literal_left:  8'd0,
    pad_pending:   1'b0
  };

endpackage

### hdl/rlebsd_cfg.sv
// Configuration registers of the RLE8 span decoder: row bytes, image bytes
// and transparent fill value. Depends on rlebsd_pkg.
`timescale 1ns / 1ps

module rlebsd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlebsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rlebsd_pkg::ImgW-1:0]     cfg_data,
  output logic [rlebsd_pkg::RowW-1:0]     row_bytes,
  output logic [rlebsd_pkg::ImgW-1:0]     image_bytes,
  output logic [7:0]                      transparent_value
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes         <= rlebsd_pkg::RowBytesReset;
      image_bytes       <= rlebsd_pkg::ImageBytesReset;
      transparent_value <= rlebsd_pkg::TranspReset;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        rlebsd_pkg::REG_ROW_BYTES:   row_bytes <= cfg_data[rlebsd_pkg::RowW-1:0];
        rlebsd_pkg::REG_IMAGE_BYTES: image_bytes <= cfg_data;
        rlebsd_pkg::REG_TRANSPARENT: transparent_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/rlebsd_decode.sv
// Next-state and result logic of the RLE8 span decoder for one code byte.
// Purely combinational. Depends on rlebsd_pkg.
`timescale 1ns / 1ps

module rlebsd_decode #(
  parameter int MAX_ROW_BYTES   = rlebsd_pkg::DefMaxRowBytes,
  parameter int MAX_IMAGE_BYTES = rlebsd_pkg::DefMaxImageBytes
) (
  input  rlebsd_pkg::dec_state_t          st,
  input  logic [7:0]                      code_byte,
  input  logic                            first_byte,
  input  logic                            final_byte,
  input  logic [rlebsd_pkg::RowW-1:0]     row_bytes,
  input  logic [rlebsd_pkg::ImgW-1:0]     image_bytes,
  input  logic [7:0]                      transparent_value,
  output rlebsd_pkg::dec_state_t          st_next,
  output rlebsd_pkg::span_res_t           res
);

  localparam int RowW  = rlebsd_pkg::RowW;
  localparam int ImgW  = rlebsd_pkg::ImgW;
  localparam int ColW  = rlebsd_pkg::ColW;
  localparam int DestW = rlebsd_pkg::DestW;
  localparam int RowMax = (1 << RowW) - 1;
  localparam int ImgMax = (1 << ImgW) - 1;
  localparam int RowCap = (MAX_ROW_BYTES > RowMax) ? RowMax : MAX_ROW_BYTES;
  localparam int ImgCap = (MAX_IMAGE_BYTES > ImgMax) ? ImgMax : MAX_IMAGE_BYTES;

  rlebsd_pkg::dec_state_t base;
  logic [RowW-1:0]   row;
  logic [ImgW-1:0]   img;
  logic [RowW-1:0]   row_left;
  logic [ImgW-1:0]   img_left;
  logic [ImgW-1:0]   eol_len;
  logic [22:0]       row_mul;
  logic [ImgW-1:0]   delta_len;
  logic [7:0]        lit_next;
  logic              code_over;

  always_comb begin
    base = first_byte ? rlebsd_pkg::StateStart : st;
    row  = (row_bytes > RowW'(RowCap)) ? RowW'(RowCap) : row_bytes;
    img  = (image_bytes > ImgW'(ImgCap)) ? ImgW'(ImgCap) : image_bytes;
    row_left = ({1'b0, row} > base.column) ? RowW'({1'b0, row} - base.column) : '0;
    img_left = ({1'b0, img} > base.dest_position)
             ? ImgW'({1'b0, img} - base.dest_position) : '0;
    eol_len  = ({9'd0, row_left} < img_left) ? {9'd0, row_left} : img_left;
    // vertical skip: whole rows plus the horizontal offset
    row_mul   = 23'(row) * 23'(code_byte);
    delta_len = ImgW'(row_mul) + ImgW'(base.delta_columns);
    lit_next  = base.literal_left - 8'd1;
    code_over = ({7'd0, code_byte} > row_left) || ({16'd0, code_byte} > img_left);
  end

  always_comb begin
    logic       bad;
    logic       done;
    logic [7:0] pv;
    logic [ImgW-1:0] len;
    bad  = 1'b0;
    done = 1'b0;
    pv   = 8'd0;
    len  = '0;
    st_next = base;
    res  = '0;
    unique case (base.phase)
      rlebsd_pkg::PH_COUNT: begin
        if (code_byte != 8'd0) begin
          if (code_over) begin
            bad = 1'b1;
          end else begin
            st_next.held_count = code_byte;
            st_next.phase      = rlebsd_pkg::PH_RUN_VALUE;
          end
        end else begin
          st_next.phase = rlebsd_pkg::PH_ESCAPE;
        end
      end
      rlebsd_pkg::PH_RUN_VALUE: begin
        pv  = code_byte;
        len = ImgW'(base.held_count);
        st_next.dest_position = base.dest_position + DestW'(base.held_count);
        st_next.column        = base.column + ColW'(base.held_count);
        st_next.phase         = rlebsd_pkg::PH_COUNT;
      end
      rlebsd_pkg::PH_ESCAPE: begin
        if (code_byte == rlebsd_pkg::ESC_EOL) begin
          pv  = transparent_value;
          len = eol_len;
          st_next.dest_position = base.dest_position + DestW'(eol_len);
          st_next.column        = '0;
          st_next.phase         = rlebsd_pkg::PH_COUNT;
        end else if (code_byte == rlebsd_pkg::ESC_EOB) begin
          done = 1'b1;
          st_next.dest_position = DestW'(img);
          st_next.phase         = rlebsd_pkg::PH_DONE;
        end else if (code_byte == rlebsd_pkg::ESC_DELTA) begin
          st_next.phase = rlebsd_pkg::PH_DELTA_X;
        end else if (code_over) begin
          bad = 1'b1;
        end else begin
          st_next.literal_left = code_byte;
          st_next.pad_pending  = code_byte[0];
          st_next.phase        = rlebsd_pkg::PH_LITERAL;
        end
      end
      rlebsd_pkg::PH_DELTA_X: begin
        st_next.delta_columns = code_byte;
        st_next.phase         = rlebsd_pkg::PH_DELTA_Y;
      end
      rlebsd_pkg::PH_DELTA_Y: begin
        if ((delta_len > img_left) || ({7'd0, base.delta_columns} > row_left)) begin
          bad = 1'b1;
        end else begin
          pv  = transparent_value;
          len = delta_len;
          st_next.dest_position = base.dest_position + DestW'(delta_len);
          st_next.column        = base.column + ColW'(base.delta_columns);
          st_next.phase         = rlebsd_pkg::PH_COUNT;
        end
      end
      rlebsd_pkg::PH_LITERAL: begin
        pv  = code_byte;
        len = ImgW'(1);
        st_next.dest_position = base.dest_position + DestW'(1);
        st_next.column        = base.column + ColW'(1);
        st_next.literal_left  = lit_next;
        if (lit_next == 8'd0) begin
          st_next.phase = base.pad_pending ? rlebsd_pkg::PH_PAD : rlebsd_pkg::PH_COUNT;
        end
      end
      rlebsd_pkg::PH_PAD: begin
        st_next.pad_pending = 1'b0;
        st_next.phase       = rlebsd_pkg::PH_COUNT;
      end
      default: ;  // done or error: swallow bytes until a restart
    endcase

    if (base.phase == rlebsd_pkg::PH_DONE || base.phase == rlebsd_pkg::PH_ERROR) begin
      res = '0;
    end else if (done) begin
      res = '{valid: 1'b1, pixel_value: transparent_value, span_length: img_left,
              status: rlebsd_pkg::ST_DONE};
    end else if (bad) begin
      st_next.phase = rlebsd_pkg::PH_ERROR;
      res = '{valid: 1'b1, pixel_value: 8'd0, span_length: '0,
              status: rlebsd_pkg::ST_ERROR};
    end else if (final_byte) begin
      // source ran out before end of bitmap
      st_next.phase = rlebsd_pkg::PH_ERROR;
      res = '{valid: 1'b1, pixel_value: (len == '0) ? 8'd0 : pv, span_length: len,
              status: rlebsd_pkg::ST_ERROR};
    end else if (len != '0) begin
      res = '{valid: 1'b1, pixel_value: pv, span_length: len,
              status: rlebsd_pkg::ST_SPAN};
    end
  end

endmodule

### hdl/rle8_bitmap_span_decoder.sv
// RLE8 bitmap span decoder takes one compressed byte per cycle while the output
// is free: every byte is decoded in the cycle it is accepted and its span, if
// any, is loaded into the output register on acceptance. The input is ready
// whenever that register is empty or being drained, so the sustained rate is
// one byte per clock; a stalled output holds the input only while a span waits.
// The per-byte path is the state decode, including a 15x8 multiply for delta
// escapes. Depends on rlebsd_pkg, rlebsd_cfg and rlebsd_decode.
`timescale 1ns / 1ps

module rle8_bitmap_span_decoder #(
  parameter int MAX_ROW_BYTES   = rlebsd_pkg::DefMaxRowBytes,
  parameter int MAX_IMAGE_BYTES = rlebsd_pkg::DefMaxImageBytes
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] code_byte
  input  logic                            s_tuser,   // [0] first_byte
  input  logic                            s_tlast,   // final_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [7:0] pixel_value, [31:8] span_length
  output logic [1:0]                      m_tuser,   // [1:0] status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlebsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rlebsd_pkg::ImgW-1:0]     cfg_data
);

  logic [rlebsd_pkg::RowW-1:0] row_bytes;
  logic [rlebsd_pkg::ImgW-1:0] image_bytes;
  logic [7:0]                  transparent_value;

  rlebsd_pkg::dec_state_t state;
  rlebsd_pkg::dec_state_t state_next;
  rlebsd_pkg::span_res_t  res;
  logic                   s_accept;
  logic                   load;

  rlebsd_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .row_bytes         (row_bytes),
    .image_bytes       (image_bytes),
    .transparent_value (transparent_value)
  );

  rlebsd_decode #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
  ) u_decode (
    .st                (state),
    .code_byte         (s_tdata),
    .first_byte        (s_tuser),
    .final_byte        (s_tlast),
    .row_bytes         (row_bytes),
    .image_bytes       (image_bytes),
    .transparent_value (transparent_value),
    .st_next           (state_next),
    .res               (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign load     = s_accept && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlebsd_pkg::StateStart;
    end else if (s_accept) begin
      state <= state_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res.span_length, res.pixel_value};
      m_tuser <= res.status;
    end
  end

`ifndef SYNTH
  a_done_enters_done_phase: assert property (@(posedge clk) disable iff (rst)
    (load && res.status == rlebsd_pkg::ST_DONE) |=> (state.phase == rlebsd_pkg::PH_DONE))
    else $error("image complete beat without done phase");

  a_quiet_after_error: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_tuser && state.phase == rlebsd_pkg::PH_ERROR) |-> !load)
    else $error("beat produced after malformed status");

  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    (load && res.status == rlebsd_pkg::ST_SPAN) |-> (res.span_length != '0))
    else $error("empty span beat");
`endif

endmodule

### dv/rle8_bitmap_span_decoder_test.sv
// Self-checking bench for rle8_bitmap_span_decoder: a directed table of RLE8
// streams, then random, mostly legal images under several register settings.
// Depends on rlebsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module rle8_bitmap_span_decoder_test;

  localparam int ImgW    = rlebsd_pkg::ImgW;
  localparam int RowW    = rlebsd_pkg::RowW;
  localparam int CfgIdxW = rlebsd_pkg::CfgIdxW;

  typedef struct packed {
    logic [7:0]      pixel;
    logic [ImgW-1:0] length;
    logic [1:0]      status;
  } span_t;

  typedef struct packed {
    logic [7:0] code;
    logic       first;
    logic       fin;
    logic       reprogram;
    logic       typed;
    logic       has;
    span_t      span;
  } dir_row_t;

  localparam int unsigned MaxRow     = rlebsd_pkg::DefMaxRowBytes;
  localparam int unsigned MaxImg     = rlebsd_pkg::DefMaxImageBytes;
  localparam logic [7:0]  EscLead    = 8'h00;
  localparam logic [7:0]  EscEol     = rlebsd_pkg::ESC_EOL;
  localparam logic [7:0]  EscEob     = rlebsd_pkg::ESC_EOB;
  localparam logic [7:0]  EscDelta   = rlebsd_pkg::ESC_DELTA;
  localparam logic [1:0]  StSpan     = rlebsd_pkg::ST_SPAN;
  localparam logic [1:0]  StDone     = rlebsd_pkg::ST_DONE;
  localparam logic [1:0]  StErr      = rlebsd_pkg::ST_ERROR;
  localparam int          PerPhase   = 80;
  localparam int          NumPhases  = 5;
  localparam int          CycleLimit = 200000;
  localparam int          LongHold   = 300;

  // small image for the last part of the table
  localparam logic [ImgW-1:0] DirRow  = 24'd4;
  localparam logic [ImgW-1:0] DirImg  = 24'd6;
  localparam logic [ImgW-1:0] DirFill = 24'h00005A;

  localparam span_t NoSpan = '0;

  localparam dir_row_t DirTable [30] = '{
    // reset registers: 640 bytes per row, 307200 bytes, fill 0
    '{8'd5,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'hAA,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'hAA, 24'd5, StSpan}},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEol,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h00, 24'd635, StSpan}},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscDelta, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'hFF,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'h01,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h00, 24'd895, StSpan}},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'd3,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'h00,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NoSpan},
    '{8'hFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NoSpan},
    '{8'h7F,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NoSpan},
    '{8'h55,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NoSpan},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEob,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h00, 24'd305662, StDone}},
    '{8'd9,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'hFF,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'h12,    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, '{8'h12, 24'd255, StErr}},
    '{8'd3,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{8'd4,     1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{8'h00, 24'd0, StErr}},
    // 4 bytes per row, 6 bytes in all, fill 5A
    '{8'd5,     1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '{8'h00, 24'd0, StErr}},
    '{EscLead,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEol,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h5A, 24'd4, StSpan}},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEol,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h5A, 24'd2, StSpan}},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEol,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscLead,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NoSpan},
    '{EscEob,   1'b0, 1'b1, 1'b0, 1'b1, 1'b1, '{8'h5A, 24'd0, StDone}}
  };

  // row_bytes, image_bytes, transparent_value per random phase
  localparam logic [ImgW-1:0] PhaseRegs [NumPhases][3] = '{
    '{24'd16,     24'd64,     24'h0000A5},
    '{24'd4,      24'd1,      24'hFFFFFF},
    '{24'hFFFFFF, 24'hFFFFFF, 24'h000000},
    '{24'd8,      24'd40,     24'h00003C},
    '{24'd40,     24'd300,    24'h000081}
  };

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid, s_tready;
  logic [7:0] s_tdata;    // [7:0] code_byte
  logic s_tuser;          // [0] first_byte
  logic s_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;   // [7:0] pixel_value, [31:8] span_length
  logic [1:0] m_tuser;    // [1:0] status
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ImgW-1:0] cfg_data;

  rle8_bitmap_span_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // decoder mirror
  logic [RowW-1:0]        row_reg;
  logic [ImgW-1:0]        img_reg;
  logic [7:0]             fill_reg;
  rlebsd_pkg::phase_t     dec_phase;
  logic [7:0]             run_count, skip_cols, lit_left;
  logic                   pad_due;
  int unsigned            col_pos, dest_pos;

  span_t spans_due [$];
  int    errors = 0;

  // typed expectation of the directed row in flight
  logic  typed_row, typed_has;
  span_t typed_span;

  bit offering = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int rx_mode = 0, rx_mode_left = 0;

  function automatic void restart_image();
    dec_phase = rlebsd_pkg::PH_COUNT;
    run_count = '0;
    col_pos   = 0;
    dest_pos  = 0;
    skip_cols = '0;
    lit_left  = '0;
    pad_due   = 1'b0;
  endfunction

  function automatic int unsigned row_limit();
    return (32'(row_reg) > MaxRow) ? MaxRow : 32'(row_reg);
  endfunction

  function automatic int unsigned img_limit();
    return (32'(img_reg) > MaxImg) ? MaxImg : 32'(img_reg);
  endfunction

  function automatic int unsigned room(int unsigned lim, int unsigned pos);
    return (lim > pos) ? lim - pos : 0;
  endfunction

  function automatic bit predict_span(input logic [7:0] code, input logic first,
                                      input logic fin, output span_t res);
    int unsigned row, img, row_left, img_left, n, len, code_w, skip_w;
    logic [7:0] pv;
    bit bad;
    pv = '0;
    len = 0;
    bad = 1'b0;
    res = '0;
    if (first) restart_image();
    row = row_limit();
    img = img_limit();
    row_left = room(row, col_pos);
    img_left = room(img, dest_pos);
    code_w = 32'(code);
    skip_w = 32'(skip_cols);
    case (dec_phase)
      rlebsd_pkg::PH_COUNT: begin
        if (code == EscLead) dec_phase = rlebsd_pkg::PH_ESCAPE;
        else if (code_w > row_left || code_w > img_left) bad = 1'b1;
        else begin
          run_count = code;
          dec_phase = rlebsd_pkg::PH_RUN_VALUE;
        end
      end
      rlebsd_pkg::PH_RUN_VALUE: begin
        pv = code;
        len = 32'(run_count);
        dest_pos += 32'(run_count);
        col_pos += 32'(run_count);
        dec_phase = rlebsd_pkg::PH_COUNT;
      end
      rlebsd_pkg::PH_ESCAPE: begin
        if (code == rlebsd_pkg::ESC_EOL) begin
          // fill to row end, clipped at the image end
          n = (row_left < img_left) ? row_left : img_left;
          pv = fill_reg;
          len = n;
          dest_pos += n;
          col_pos = 0;
          dec_phase = rlebsd_pkg::PH_COUNT;
        end else if (code == rlebsd_pkg::ESC_EOB) begin
          dest_pos = img;
          dec_phase = rlebsd_pkg::PH_DONE;
          res.pixel = fill_reg;
          res.length = img_left[ImgW-1:0];
          res.status = rlebsd_pkg::ST_DONE;
          return 1'b1;
        end else if (code == rlebsd_pkg::ESC_DELTA) begin
          dec_phase = rlebsd_pkg::PH_DELTA_X;
        end else if (code_w > row_left || code_w > img_left) begin
          bad = 1'b1;
        end else begin
          lit_left = code;
          pad_due = code[0];
          dec_phase = rlebsd_pkg::PH_LITERAL;
        end
      end
      rlebsd_pkg::PH_DELTA_X: begin
        skip_cols = code;
        dec_phase = rlebsd_pkg::PH_DELTA_Y;
      end
      rlebsd_pkg::PH_DELTA_Y: begin
        n = skip_w + row * code_w;
        if (n > img_left || skip_w > row_left) bad = 1'b1;
        else begin
          pv = fill_reg;
          len = n;
          dest_pos += n;
          col_pos += skip_w;
          dec_phase = rlebsd_pkg::PH_COUNT;
        end
      end
      rlebsd_pkg::PH_LITERAL: begin
        pv = code;
        len = 1;
        dest_pos += 1;
        col_pos += 1;
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0)
          dec_phase = pad_due ? rlebsd_pkg::PH_PAD : rlebsd_pkg::PH_COUNT;
      end
      rlebsd_pkg::PH_PAD: begin
        pad_due = 1'b0;
        dec_phase = rlebsd_pkg::PH_COUNT;
      end
      default: return 1'b0;
    endcase
    if (bad) begin
      dec_phase = rlebsd_pkg::PH_ERROR;
      res.status = rlebsd_pkg::ST_ERROR;
      return 1'b1;
    end
    if (fin && dec_phase != rlebsd_pkg::PH_DONE) begin
      dec_phase = rlebsd_pkg::PH_ERROR;
      if (len == 0) pv = '0;
      res.pixel = pv;
      res.length = len[ImgW-1:0];
      res.status = rlebsd_pkg::ST_ERROR;
      return 1'b1;
    end
    if (len > 0) begin
      res.pixel = pv;
      res.length = len[ImgW-1:0];
      res.status = rlebsd_pkg::ST_SPAN;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Choose the next byte from the mirror state: mostly a legal stream, with
  // noise, early ends, restarts and bytes that land after an image closed.
  task automatic pick_code(output logic [7:0] code, output logic first,
                           output logic fin, output bit counts);
    int unsigned rl, il, lim, pct, maxdy, skip_w;
    rlebsd_pkg::phase_t at;
    code = '0;
    first = 1'b0;
    fin = 1'b0;
    counts = 1'b1;
    at = dec_phase;
    rl = room(row_limit(), col_pos);
    il = room(img_limit(), dest_pos);
    skip_w = 32'(skip_cols);
    if (at == rlebsd_pkg::PH_DONE || at == rlebsd_pkg::PH_ERROR) begin
      if ($urandom_range(0, 5) == 0) begin
        code = 8'($urandom_range(0, 255));
        fin = 1'($urandom_range(0, 1));
        counts = 1'b0;
        return;
      end
      first = 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      first = 1'b1;
    end
    if (first) begin
      at = rlebsd_pkg::PH_COUNT;
      rl = row_limit();
      il = img_limit();
    end
    lim = (rl < il) ? rl : il;
    if (lim > 255) lim = 255;
    pct = $urandom_range(0, 99);
    case (at)
      rlebsd_pkg::PH_COUNT: begin
        if (pct < 8) code = 8'($urandom_range(0, 255));
        else if (pct < 55 && lim > 0) code = 8'($urandom_range(1, lim));
        else code = EscLead;
      end
      rlebsd_pkg::PH_ESCAPE: begin
        if (pct < 6) code = 8'($urandom_range(0, 255));
        else if (pct < 30) code = rlebsd_pkg::ESC_EOL;
        else if (pct < 40) code = rlebsd_pkg::ESC_EOB;
        else if (pct < 60) code = rlebsd_pkg::ESC_DELTA;
        else if (lim >= 3) begin
          // keep most literals short
          if ($urandom_range(0, 4) == 0) code = 8'($urandom_range(3, lim));
          else code = 8'($urandom_range(3, (lim < 8) ? lim : 8));
        end else code = rlebsd_pkg::ESC_EOL;
      end
      rlebsd_pkg::PH_DELTA_X: begin
        if (pct < 5) code = 8'($urandom_range(0, 255));
        else code = 8'($urandom_range(0, (rl < 255) ? rl : 255));
      end
      rlebsd_pkg::PH_DELTA_Y: begin
        if (pct < 5 || il < skip_w) code = 8'($urandom_range(0, 255));
        else begin
          maxdy = (il - skip_w) / row_limit();
          code = 8'($urandom_range(0, (maxdy < 3) ? maxdy : 3));
        end
      end
      default: code = 8'($urandom_range(0, 255));
    endcase
    if (at == rlebsd_pkg::PH_ESCAPE && code == rlebsd_pkg::ESC_EOB)
      fin = 1'($urandom_range(0, 1));
    else if ($urandom_range(0, 79) == 0) fin = 1'b1;
  endtask

  task automatic stop_sending();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one byte and hold it until the beat is taken.
  task automatic send_code(input logic [7:0] code, input logic first, input logic fin,
                           input logic typed, input logic has, input span_t span);
    s_tvalid <= 1'b1;
    s_tdata <= code;
    s_tuser <= first;
    s_tlast <= fin;
    typed_row <= typed;
    typed_has <= has;
    typed_span <= span;
    offering = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic pace();
    if (steady || burst_left != 0) begin
      if (burst_left != 0) burst_left--;
    end else begin
      stop_sending();
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = int'($urandom_range(0, 24));
    end
  endtask

  // Hold input until every span is back, then let the block settle.
  task automatic drain();
    stop_sending();
    while (spans_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ImgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [ImgW-1:0] row, input logic [ImgW-1:0] img,
                              input logic [ImgW-1:0] fill);
    write_reg(rlebsd_pkg::REG_ROW_BYTES, row);
    write_reg(rlebsd_pkg::REG_IMAGE_BYTES, img);
    write_reg(rlebsd_pkg::REG_TRANSPARENT, fill);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random ready modes, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LongHold;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= int'($urandom_range(0, 2));
        rx_mode_left <= int'($urandom_range(10, 80));
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : scoreboard
    span_t seen, want, guess;
    bit has;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen = '{m_tdata[7:0], m_tdata[31:8], m_tuser};
        if (spans_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected span: pixel %02h length %0d status %0d",
                     seen.pixel, seen.length, seen.status);
        end else begin
          want = spans_due.pop_front();
          if (seen.pixel !== want.pixel || seen.length !== want.length ||
              seen.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("span mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       want.pixel, want.length, want.status,
                       seen.pixel, seen.length, seen.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rlebsd_pkg::REG_ROW_BYTES:   row_reg = cfg_data[RowW-1:0];
          rlebsd_pkg::REG_IMAGE_BYTES: img_reg = cfg_data;
          rlebsd_pkg::REG_TRANSPARENT: fill_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        has = predict_span(s_tdata, s_tuser, s_tlast, guess);
        if (typed_row) begin
          if (typed_has) spans_due.push_back(typed_span);
        end else if (has) begin
          spans_due.push_back(guess);
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] code;
    logic first, fin;
    bit counts;
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_row = 1'b0;
    typed_has = 1'b0;
    typed_span = '0;
    row_reg = rlebsd_pkg::RowBytesReset;
    img_reg = rlebsd_pkg::ImageBytesReset;
    fill_reg = rlebsd_pkg::TranspReset;
    restart_image();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirTable[i]) begin
      if (DirTable[i].reprogram) begin
        drain();
        program_regs(DirRow, DirImg, DirFill);
      end
      send_code(DirTable[i].code, DirTable[i].first, DirTable[i].fin,
                DirTable[i].typed, DirTable[i].has, DirTable[i].span);
      pace();
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      program_regs(PhaseRegs[p][0], PhaseRegs[p][1], PhaseRegs[p][2]);
      n = 0;
      while (n < PerPhase) begin
        pick_code(code, first, fin, counts);
        // stall the receiver for a long stretch while bytes keep coming
        if (p == 0 && n == 20 && counts) begin
          hold_reqs <= hold_reqs + 1;
          steady = 1'b1;
        end
        if (p == 0 && n == 60) steady = 1'b0;
        send_code(code, first, fin, 1'b0, 1'b0, NoSpan);
        pace();
        if (counts) n++;
      end
    end

    stop_sending();
    while (spans_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### rle8_bitmap_span_decoder.f
hdl/rlebsd_pkg.sv
hdl/rlebsd_cfg.sv
hdl/rlebsd_decode.sv
hdl/rle8_bitmap_span_decoder.sv
dv/rle8_bitmap_span_decoder_test.sv
